FILE: rtl/core/mgrs_pkg.sv
`timescale 1ns / 1ps

package mgrs_pkg;

	// status codes of a result item
	localparam logic [3:0] ST_OK      = 4'd0;
	localparam logic [3:0] ST_ZONE    = 4'd1;
	localparam logic [3:0] ST_OFFSET  = 4'd2;
	localparam logic [3:0] ST_SVALB   = 4'd3;
	localparam logic [3:0] ST_NORWAY  = 4'd4;
	localparam logic [3:0] ST_ROW     = 4'd5;
	localparam logic [3:0] ST_COLUMN  = 4'd6;
	localparam logic [3:0] ST_BAND    = 4'd7;
	localparam logic [3:0] ST_LETTER  = 4'd8;

	// letter indices
	localparam logic [4:0] LTR_C = 5'd2;
	localparam logic [4:0] LTR_D = 5'd3;
	localparam logic [4:0] LTR_E = 5'd4;
	localparam logic [4:0] LTR_I = 5'd8;
	localparam logic [4:0] LTR_J = 5'd9;
	localparam logic [4:0] LTR_L = 5'd11;
	localparam logic [4:0] LTR_M = 5'd12;
	localparam logic [4:0] LTR_N = 5'd13;
	localparam logic [4:0] LTR_O = 5'd14;
	localparam logic [4:0] LTR_R = 5'd17;
	localparam logic [4:0] LTR_S = 5'd18;
	localparam logic [4:0] LTR_U = 5'd20;
	localparam logic [4:0] LTR_V = 5'd21;
	localparam logic [4:0] LTR_W = 5'd22;
	localparam logic [4:0] LTR_X = 5'd23;
	localparam logic [4:0] LTR_Y = 5'd24;
	localparam logic [4:0] LTR_Z = 5'd25;
	localparam logic [4:0] LTR_P = 5'd15;

	localparam logic [5:0] ZONE_MAX = 6'd60;
	localparam logic [5:0] ZONE_31  = 6'd31;
	localparam logic [5:0] ZONE_32  = 6'd32;
	localparam logic [5:0] ZONE_34  = 6'd34;
	localparam logic [5:0] ZONE_36  = 6'd36;

	localparam logic [16:0] MAX_SQUARE = 17'd100000;
	localparam logic [21:0] SQUARE_M   = 22'd100000;
	localparam logic [21:0] EVEN_SHIFT = 22'd500000;
	localparam logic [21:0] TWO_M      = 22'd2000000;

	// valid UTM bands: C..H, J..N, P..X
	localparam logic [25:0] BAND_OK = 26'h0FFBEFC;

	typedef struct packed {
		logic [5:0]  zone_number;
		logic [4:0]  band_letter;
		logic [4:0]  column_letter;
		logic [4:0]  row_letter;
		logic [16:0] square_easting;
		logic [16:0] square_northing;
	} req_t;

	typedef struct packed {
		logic [3:0]  status_code;
		logic        north_hemisphere;
		logic        is_polar;
		logic [21:0] full_easting;
		logic [23:0] full_northing;
	} rsp_t;

	// after checks and table lookups
	typedef struct packed {
		logic [3:0]  status;
		logic        north;
		logic        polar;
		logic [4:0]  col_idx;
		logic [21:0] e_add;
		logic [21:0] row_n;
		logic [23:0] n_add;
		logic [23:0] band_min;
		logic [16:0] se;
		logic [16:0] sn;
	} s1_t;

	// square origin in full coordinates
	typedef struct packed {
		logic [3:0]  status;
		logic        north;
		logic        polar;
		logic [21:0] ge;
		logic [23:0] gn;
		logic [23:0] band_min;
		logic [16:0] se;
		logic [16:0] sn;
	} s2_t;

	function automatic logic letter_bad(input logic [4:0] v);
		return (v > LTR_Z) || (v == LTR_I) || (v == LTR_O);
	endfunction

	// zone mod 3 by subtracting multiples of three
	function automatic logic [1:0] zone_set(input logic [5:0] zone);
		logic [5:0] v;
		v = zone;
		if (v >= 6'd48) v = v - 6'd48;
		if (v >= 6'd24) v = v - 6'd24;
		if (v >= 6'd12) v = v - 6'd12;
		if (v >= 6'd6)  v = v - 6'd6;
		if (v >= 6'd3)  v = v - 6'd3;
		return v[1:0];
	endfunction

	// northing of a row letter, skipping I and O
	function automatic logic [21:0] row_base(input logic [4:0] row);
		logic [21:0] n;
		n = 22'(row) * SQUARE_M;
		if (row > LTR_I) n = n - SQUARE_M;
		if (row > LTR_O) n = n - SQUARE_M;
		return n;
	endfunction

	// row northing with the even zone shift, wrapped into 0..2000000
	function automatic logic [21:0] row_north(input logic [4:0] row, input logic even);
		logic [21:0] n;
		n = row_base(row);
		if (even) begin
			if (n < EVEN_SHIFT) n = n + (TWO_M - EVEN_SHIFT);
			else n = n - EVEN_SHIFT;
		end
		return n;
	endfunction

	function automatic logic [23:0] band_min(input logic [4:0] band);
		logic [23:0] r;
		unique case (band)
			5'd2:    r = 24'd1100000;
			5'd3:    r = 24'd2000000;
			5'd4:    r = 24'd2800000;
			5'd5:    r = 24'd3700000;
			5'd6:    r = 24'd4600000;
			5'd7:    r = 24'd5500000;
			5'd9:    r = 24'd6400000;
			5'd10:   r = 24'd7300000;
			5'd11:   r = 24'd8200000;
			5'd12:   r = 24'd9100000;
			5'd15:   r = 24'd800000;
			5'd16:   r = 24'd1700000;
			5'd17:   r = 24'd2600000;
			5'd18:   r = 24'd3500000;
			5'd19:   r = 24'd4400000;
			5'd20:   r = 24'd5300000;
			5'd21:   r = 24'd6200000;
			5'd22:   r = 24'd7000000;
			5'd23:   r = 24'd7900000;
			default: r = 24'd0;
		endcase
		return r;
	endfunction

	function automatic logic [23:0] band_off(input logic [4:0] band);
		logic [23:0] r;
		unique case (band)
			5'd3, 5'd4, 5'd5, 5'd17, 5'd18:    r = 24'd2000000;
			5'd6, 5'd7, 5'd19, 5'd20:          r = 24'd4000000;
			5'd9, 5'd10, 5'd21, 5'd22, 5'd23:  r = 24'd6000000;
			5'd11, 5'd12:                      r = 24'd8000000;
			default:                           r = 24'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/mgrs_check.sv
`timescale 1ns / 1ps

module mgrs_check (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          load,
	input  mgrs_pkg::req_t req,
	output logic          valid_s1,
	output mgrs_pkg::s1_t data_s1
);
	import mgrs_pkg::*;

	logic [5:0]  zone;
	logic [4:0]  band, col, row;
	logic [1:0]  zset, k;
	logic [4:0]  u_lo, u_hi, p_lo, p_hi, p_row_hi;
	logic        polar_band, polar_gap, is_ups;
	logic [3:0]  utm_st, ups_st, st;
	logic [21:0] utm_e, ups_e, p_n0;
	s1_t         nxt;

	// polar column gaps D, E, M, N, V, W
	always_comb begin
		case (col) inside
			LTR_D, LTR_E, LTR_M, LTR_N, LTR_V, LTR_W: polar_gap = 1'b1;
			default:                                  polar_gap = 1'b0;
		endcase
	end

	always_comb begin
		zone = req.zone_number;
		band = req.band_letter;
		col  = req.column_letter;
		row  = req.row_letter;
		zset = zone_set(zone);
		is_ups = (zone == 6'd0);

		unique case (zset)
			2'd1:    begin u_lo = 5'd0;  u_hi = 5'd7;  end
			2'd2:    begin u_lo = LTR_J; u_hi = LTR_R; end
			default: begin u_lo = LTR_S; u_hi = LTR_Z; end
		endcase

		// polar band order A, B, Y, Z
		k = {band[4], band[0]};
		polar_band = (band == 5'd0) || (band == 5'd1) || (band == LTR_Y) || (band == LTR_Z);
		p_lo     = k[0] ? 5'd0 : LTR_J;
		p_hi     = (k == 2'd1) ? LTR_R : ((k == 2'd3) ? LTR_J : LTR_Z);
		p_row_hi = k[1] ? LTR_P : LTR_Z;
		p_n0     = k[1] ? 22'd1300000 : 22'd800000;

		// utm checks in priority order
		if (req.square_easting > MAX_SQUARE || req.square_northing > MAX_SQUARE)
			utm_st = ST_OFFSET;
		else if (band == LTR_X && (zone == ZONE_32 || zone == ZONE_34 || zone == ZONE_36))
			utm_st = ST_SVALB;
		else if (band == LTR_V && zone == ZONE_31 && col > LTR_D)
			utm_st = ST_NORWAY;
		else if (row > LTR_V)
			utm_st = ST_ROW;
		else if (col < u_lo || col > u_hi)
			utm_st = ST_COLUMN;
		else if (!BAND_OK[band])
			utm_st = ST_BAND;
		else
			utm_st = ST_OK;

		if (!polar_band)
			ups_st = ST_BAND;
		else if (col < p_lo || col > p_hi || polar_gap)
			ups_st = ST_COLUMN;
		else if (row > p_row_hi)
			ups_st = ST_ROW;
		else
			ups_st = ST_OK;

		if (zone > ZONE_MAX)
			st = ST_ZONE;
		else if (letter_bad(band) || letter_bad(col) || letter_bad(row))
			st = ST_LETTER;
		else if (is_ups)
			st = ups_st;
		else
			st = utm_st;

		// column offset added on top of col_idx * 100 km
		utm_e = (zset == 2'd2 && col > LTR_O) ? 22'd0 : SQUARE_M;
		if (k[0]) begin
			ups_e = 22'd2000000;
			if (col > LTR_C) ups_e = ups_e - 22'd200000;
			if (col > LTR_I) ups_e = ups_e - 22'd100000;
			if (col > LTR_L) ups_e = ups_e - 22'd300000;
		end else begin
			ups_e = 22'd800000;
			if (col > LTR_L) ups_e = ups_e - 22'd300000;
			if (col > LTR_U) ups_e = ups_e - 22'd200000;
		end

		nxt.status   = st;
		nxt.polar    = (st == ST_OK) && is_ups;
		nxt.north    = (st == ST_OK) && (is_ups ? (band >= LTR_Y) : (band >= LTR_N));
		nxt.col_idx  = col - (is_ups ? p_lo : u_lo);
		nxt.e_add    = is_ups ? ups_e : utm_e;
		nxt.row_n    = is_ups ? row_base(row) : row_north(row, !zone[0]);
		nxt.n_add    = is_ups ? 24'(p_n0) : band_off(band);
		nxt.band_min = is_ups ? 24'd0 : band_min(band);
		nxt.se       = req.square_easting;
		nxt.sn       = req.square_northing;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			data_s1 <= nxt;
		end
	end

endmodule

FILE: rtl/core/mgrs_base.sv
`timescale 1ns / 1ps

module mgrs_base (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          load,
	input  mgrs_pkg::s1_t data_s1,
	output logic          valid_s2,
	output mgrs_pkg::s2_t data_s2
);
	import mgrs_pkg::*;

	s2_t nxt;

	// square origin: column times 100 km plus offset, row northing plus band offset
	always_comb begin
		nxt.status   = data_s1.status;
		nxt.north    = data_s1.north;
		nxt.polar    = data_s1.polar;
		nxt.ge       = 22'(data_s1.col_idx) * SQUARE_M + data_s1.e_add;
		nxt.gn       = 24'(data_s1.row_n) + data_s1.n_add;
		nxt.band_min = data_s1.band_min;
		nxt.se       = data_s1.se;
		nxt.sn       = data_s1.sn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			data_s2 <= nxt;
		end
	end

endmodule

FILE: rtl/core/mgrs_sum.sv
`timescale 1ns / 1ps

module mgrs_sum (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          load,
	input  mgrs_pkg::s2_t data_s2,
	output logic          valid_s3,
	output mgrs_pkg::rsp_t data_s3
);
	import mgrs_pkg::*;

	logic        below;
	logic [23:0] wrap;
	rsp_t        nxt;

	always_comb begin
		// northing below the band floor belongs to the next 2000 km cycle
		below = data_s2.gn < data_s2.band_min;
		wrap  = below ? 24'(TWO_M) : 24'd0;
		nxt.status_code      = data_s2.status;
		nxt.north_hemisphere = data_s2.north;
		nxt.is_polar         = data_s2.polar;
		if (data_s2.status == ST_OK) begin
			nxt.full_easting  = data_s2.ge + 22'(data_s2.se);
			nxt.full_northing = data_s2.gn + wrap + 24'(data_s2.sn);
		end else begin
			nxt.full_easting  = 22'd0;
			nxt.full_northing = 24'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (load) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			data_s3 <= nxt;
		end
	end

endmodule

FILE: rtl/core/mgrs_grid_square_to_utm_ups.sv
// MGRS grid square decoder: each item on req is one parsed MGRS reference (zone, band,
// column and row letters, metres inside the 100 km square) and produces exactly one item
// on rsp holding a status code and, when the status is ok, the full UTM easting and
// northing (zones 1 to 60) or the full UPS easting and northing (zone 0, bands A, B, Y,
// Z), all in whole metres. Failed items carry zeros in every field but the status. The
// block takes one item per clock cycle while rsp_stall is low, through three pipeline
// stages (checks and table lookups, square origin, final offset add), each with its own
// valid bit. rsp_stall holds the pipeline; req_stall rises only when every stage holds an
// item that cannot move, so bubbles are squeezed out while the output waits.
`timescale 1ns / 1ps

module mgrs_grid_square_to_utm_ups (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  mgrs_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output mgrs_pkg::rsp_t rsp
);
	import mgrs_pkg::*;

	logic valid_s1, valid_s2, valid_s3;
	logic load_s1, load_s2, load_s3;
	s1_t  data_s1;
	s2_t  data_s2;
	rsp_t data_s3;

	// a stage loads when it is empty or its content moves on
	assign load_s3   = !valid_s3 || !rsp_stall;
	assign load_s2   = !valid_s2 || load_s3;
	assign load_s1   = !valid_s1 || load_s2;
	assign req_stall = !load_s1;

	// stage 1: validation, zone set, letter tables
	mgrs_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req_valid),
		.load     (load_s1),
		.req      (req),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	// stage 2: origin of the 100 km square
	mgrs_base u_base (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.load     (load_s2),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	// stage 3: band wrap and in-square offsets, doubles as output register
	mgrs_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s2),
		.load     (load_s3),
		.data_s2  (data_s2),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	assign rsp_valid = valid_s3;
	assign rsp       = data_s3;

`ifndef ASSERT_OFF
	// failed items carry no coordinates or flags
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status_code != ST_OK) |->
		(rsp.full_easting == 22'd0 && rsp.full_northing == 24'd0 &&
		 !rsp.is_polar && !rsp.north_hemisphere))
		else $error("failed item has nonzero result fields");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status_code <= ST_LETTER))
		else $error("status code out of range");

	// an empty output stage never backs up the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s3 |-> !req_stall)
		else $error("input stalled with empty output stage");

	// full and held pipeline must stall the input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && rsp_stall) |-> req_stall)
		else $error("input not stalled with full held pipeline");
`endif

endmodule

FILE: tb/sv/mgrs_grid_square_to_utm_ups_tb.sv
`timescale 1ns / 1ps

import mgrs_pkg::*;

// letters that the package does not name
localparam logic [4:0] LT_A = 5'd0;
localparam logic [4:0] LT_B = 5'd1;
localparam logic [4:0] LT_H = 5'd7;
localparam logic [4:0] LT_K = 5'd10;
localparam logic [4:0] LT_Q = 5'd16;
localparam logic [4:0] NOT_LETTER = 5'd26;

localparam int SQUARE_SPAN = 100000;
localparam int FALSE_SHIFT = 500000;
localparam int NORTH_WRAP  = 2000000;

// polar columns that never carry a square
localparam logic [25:0] POLAR_SKIP = (26'd1 << LTR_D) | (26'd1 << LTR_E) | (26'd1 << LTR_M) |
	(26'd1 << LTR_N) | (26'd1 << LTR_V) | (26'd1 << LTR_W);

// holds the decoded coordinates still owed by the block, oldest first
class decode_ledger;
	rsp_t        awaited[$];
	int unsigned mismatches;
	int          band_floor_hk[26];
	int          band_lift_hk[26];

	function new();
		mismatches = 0;
		// lowest northing and northing lift of each band, in units of 100 km
		band_floor_hk = '{0, 0, 11, 20, 28, 37, 46, 55, 0, 64, 73, 82, 91, 0, 0,
			8, 17, 26, 35, 44, 53, 62, 70, 79, 0, 0};
		band_lift_hk = '{0, 0, 0, 20, 20, 20, 40, 40, 0, 60, 60, 80, 80, 0, 0,
			0, 0, 20, 20, 40, 40, 60, 60, 60, 0, 0};
	endfunction

	function bit not_a_letter(logic [4:0] v);
		return v > LTR_Z || v == LTR_I || v == LTR_O;
	endfunction

	// northing of a row letter, I and O skipped
	function int row_floor(int row);
		int n;
		n = row;
		if (row > LTR_I) n--;
		if (row > LTR_O) n--;
		return n * SQUARE_SPAN;
	endfunction

	function rsp_t decode_reference(req_t r);
		rsp_t f;
		int zone, band, col, row, lo, hi, rhi, ge, gn, e0, n0;
		f = '0;
		zone = r.zone_number;
		band = r.band_letter;
		col = r.column_letter;
		row = r.row_letter;
		lo = 0;
		hi = 0;
		rhi = 0;
		e0 = 0;
		n0 = 0;
		if (zone > ZONE_MAX) begin
			f.status_code = ST_ZONE;
		end else if (not_a_letter(r.band_letter) || not_a_letter(r.column_letter) ||
				not_a_letter(r.row_letter)) begin
			f.status_code = ST_LETTER;
		end else if (zone == 0) begin
			f.status_code = ST_OK;
			case (r.band_letter)
				LT_A: begin
					lo = LTR_J; hi = LTR_Z; rhi = LTR_Z; e0 = 800000; n0 = 800000;
				end
				LT_B: begin
					lo = LT_A; hi = LTR_R; rhi = LTR_Z; e0 = 2000000; n0 = 800000;
				end
				LTR_Y: begin
					lo = LTR_J; hi = LTR_Z; rhi = LTR_P; e0 = 800000; n0 = 1300000;
				end
				LTR_Z: begin
					lo = LT_A; hi = LTR_J; rhi = LTR_P; e0 = 2000000; n0 = 1300000;
				end
				default: f.status_code = ST_BAND;
			endcase
			if (f.status_code == ST_OK) begin
				if (col < lo || col > hi || POLAR_SKIP[col]) begin
					f.status_code = ST_COLUMN;
				end else if (row > rhi) begin
					f.status_code = ST_ROW;
				end else begin
					ge = (col - lo) * SQUARE_SPAN + e0;
					if (lo != 0) begin
						if (col > LTR_L) ge -= 300000;
						if (col > LTR_U) ge -= 200000;
					end else begin
						if (col > LTR_C) ge -= 200000;
						if (col > LTR_I) ge -= 100000;
						if (col > LTR_L) ge -= 300000;
					end
					gn = row_floor(row) + n0;
					f.is_polar = 1'b1;
					f.north_hemisphere = band >= LTR_Y;
					f.full_easting = 22'(ge + int'(r.square_easting));
					f.full_northing = 24'(gn + int'(r.square_northing));
				end
			end
		end else begin
			if (r.square_easting > MAX_SQUARE || r.square_northing > MAX_SQUARE) begin
				f.status_code = ST_OFFSET;
			end else if (r.band_letter == LTR_X &&
					(zone == ZONE_32 || zone == ZONE_34 || zone == ZONE_36)) begin
				f.status_code = ST_SVALB;
			end else if (r.band_letter == LTR_V && zone == ZONE_31 && col > LTR_D) begin
				f.status_code = ST_NORWAY;
			end else if (row > LTR_V) begin
				f.status_code = ST_ROW;
			end else begin
				case (zone % 3)
					1: begin lo = LT_A; hi = LT_H; end
					2: begin lo = LTR_J; hi = LTR_R; end
					default: begin lo = LTR_S; hi = LTR_Z; end
				endcase
				if (col < lo || col > hi) begin
					f.status_code = ST_COLUMN;
				end else if (!BAND_OK[band]) begin
					f.status_code = ST_BAND;
				end else begin
					ge = (col - lo + 1) * SQUARE_SPAN;
					if (lo == LTR_J && col > LTR_O) ge -= SQUARE_SPAN;
					gn = row_floor(row);
					if (zone % 2 == 0) gn -= FALSE_SHIFT;
					if (gn < 0) gn += NORTH_WRAP;
					gn += band_lift_hk[band] * SQUARE_SPAN;
					if (gn < band_floor_hk[band] * SQUARE_SPAN) gn += NORTH_WRAP;
					f.status_code = ST_OK;
					f.north_hemisphere = band >= LTR_N;
					f.full_easting = 22'(ge + int'(r.square_easting));
					f.full_northing = 24'(gn + int'(r.square_northing));
				end
			end
		end
		return f;
	endfunction

	function void note_reference(req_t r);
		awaited.push_back(decode_reference(r));
	endfunction

	function void flag(string what, rsp_t want, rsp_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: want st=%0d nh=%0b up=%0b e=%0d n=%0d got st=%0d nh=%0b up=%0b e=%0d n=%0d",
				what, want.status_code, want.north_hemisphere, want.is_polar,
				want.full_easting, want.full_northing, got.status_code,
				got.north_hemisphere, got.is_polar, got.full_easting, got.full_northing);
	endfunction

	function void check_fix(rsp_t got);
		rsp_t want;
		if (awaited.size() == 0) begin
			flag("result with nothing pending", '0, got);
			return;
		end
		want = awaited.pop_front();
		if (got.status_code !== want.status_code ||
				got.north_hemisphere !== want.north_hemisphere ||
				got.is_polar !== want.is_polar ||
				got.full_easting !== want.full_easting ||
				got.full_northing !== want.full_northing)
			flag("result differs", want, got);
	endfunction
endclass

module mgrs_grid_square_to_utm_ups_tb;

	localparam int unsigned RANDOM_ITEMS  = 900;
	localparam int unsigned IDLE_LIMIT    = 2000;
	localparam int unsigned SETTLE_CYCLES = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	decode_ledger ledger;
	// no gaps and no stalls on either side while set
	bit calm = 1'b0;
	int unsigned idle_cycles = 0;

	mgrs_grid_square_to_utm_ups uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// gap length: mostly none, some short, a few long
	function automatic int unsigned idle_span();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 85) return $urandom_range(3, 1);
		if (p < 96) return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	// random letter in lo..hi, never I or O nor any letter in skip
	function automatic logic [4:0] pick_letter(int unsigned lo, int unsigned hi,
			logic [25:0] skip);
		logic [4:0] v;
		do
			v = 5'($urandom_range(hi, lo));
		while (v == LTR_I || v == LTR_O || skip[v]);
		return v;
	endfunction

	// in-square metres, edges and the out-of-range tail now and then
	function automatic logic [16:0] square_metres();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 5) return '0;
		if (p < 10) return MAX_SQUARE;
		if (p < 14) return 17'($urandom_range(131071, 100001));
		return 17'($urandom_range(100000));
	endfunction

	function automatic req_t reference_of(logic [5:0] zone, logic [4:0] band, logic [4:0] col,
			logic [4:0] row, logic [16:0] se, logic [16:0] sn);
		req_t r;
		r.zone_number = zone;
		r.band_letter = band;
		r.column_letter = col;
		r.row_letter = row;
		r.square_easting = se;
		r.square_northing = sn;
		return r;
	endfunction

	// offer one item after a random gap; with drain the sender first waits
	// until every owed result is back
	task automatic send_reference(input req_t r, input bit drain);
		int unsigned gap;
		gap = calm ? 0 : idle_span();
		if (drain && gap == 0) gap = 1;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			if (drain)
				while (ledger.awaited.size() != 0) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		ledger.note_reference(r);
	endtask

	// result side: check every accepted item, stall in random bursts
	initial begin : rsp_side
		int unsigned hold;
		bit stalling;
		hold = 0;
		stalling = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) ledger.check_fix(rsp);
			if (calm) begin
				stalling = 1'b0;
				hold = 0;
			end else if (hold != 0) begin
				hold--;
			end else if (stalling) begin
				stalling = 1'b0;
				hold = $urandom_range(24, 1);
			end else begin
				hold = idle_span();
				stalling = hold != 0;
			end
			rsp_stall <= stalling;
		end
	end

	// watchdog: too long without any item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : req_side
		req_t item;
		int unsigned i, pick, lo, hi, rhi;
		ledger = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zone above sixty, zone checked ahead of letters
		send_reference(reference_of(6'd61, LTR_C, LT_A, LT_A, 17'd0, 17'd0), 1'b0);
		send_reference(reference_of(6'd63, NOT_LETTER, LT_A, LT_A, 17'd0, 17'd0), 1'b0);
		// letters I, O and a value past Z
		send_reference(reference_of(6'd5, LTR_I, LT_A, LT_A, 17'd0, 17'd0), 1'b0);
		send_reference(reference_of(6'd0, LT_A, LTR_O, LT_A, 17'd0, 17'd0), 1'b0);
		send_reference(reference_of(6'd7, LTR_C, LT_A, NOT_LETTER, 17'd0, 17'd0), 1'b0);
		// utm corners
		send_reference(reference_of(6'd1, LTR_C, LT_A, LT_A, 17'd0, 17'd0), 1'b0);
		send_reference(reference_of(ZONE_MAX, LTR_X, LTR_Z, LTR_V, MAX_SQUARE, MAX_SQUARE),
			1'b0);
		send_reference(reference_of(6'd2, LTR_M, LTR_J, LT_A, 17'd1, 17'd99999), 1'b0);
		// offsets past one square
		send_reference(reference_of(6'd1, LTR_C, LT_A, LT_A, 17'd100001, 17'd0), 1'b0);
		send_reference(reference_of(6'd1, LTR_C, LT_A, LT_A, 17'd0, 17'h1FFFF), 1'b0);
		// svalbard zones in band X
		send_reference(reference_of(ZONE_32, LTR_X, LTR_J, LT_A, 17'd0, 17'd0), 1'b0);
		send_reference(reference_of(ZONE_34, LTR_X, LT_A, LT_A, 17'd0, 17'd0), 1'b0);
		send_reference(reference_of(ZONE_36, LTR_X, LTR_S, LT_A, 17'd0, 17'd0), 1'b0);
		// norway: zone 31 band V, column past D and at D
		send_reference(reference_of(ZONE_31, LTR_V, LTR_E, LT_A, 17'd0, 17'd0), 1'b0);
		send_reference(reference_of(ZONE_31, LTR_V, LTR_D, LTR_C, 17'd5, 17'd5), 1'b0);
		// row past V, column outside the zone set, polar band on utm
		send_reference(reference_of(6'd1, LTR_C, LT_A, LTR_W, 17'd0, 17'd0), 1'b0);
		send_reference(reference_of(6'd2, LTR_C, LT_A, LT_A, 17'd0, 17'd0), 1'b0);
		send_reference(reference_of(6'd3, LT_A, LTR_S, LT_A, 17'd0, 17'd0), 1'b0);
		send_reference(reference_of(6'd4, LTR_Z, LT_A, LT_A, 17'd0, 17'd0), 1'b0);
		// ups: bad band, each polar band at its edges
		send_reference(reference_of(6'd0, LTR_C, LTR_J, LT_A, 17'd0, 17'd0), 1'b0);
		send_reference(reference_of(6'd0, LT_A, LTR_J, LTR_Z, 17'd0, 17'd0), 1'b0);
		send_reference(reference_of(6'd0, LT_B, LT_A, LTR_Z, 17'h1FFFF, 17'h1FFFF), 1'b0);
		send_reference(reference_of(6'd0, LTR_Y, LTR_Z, LTR_P, 17'd0, 17'd0), 1'b0);
		send_reference(reference_of(6'd0, LTR_Z, LTR_J, LTR_P, 17'd0, 17'd0), 1'b0);
		// ups: skipped column, column past the band, row past the band
		send_reference(reference_of(6'd0, LT_A, LTR_N, LT_A, 17'd0, 17'd0), 1'b0);
		send_reference(reference_of(6'd0, LTR_Z, LT_K, LT_A, 17'd0, 17'd0), 1'b0);
		send_reference(reference_of(6'd0, LTR_Y, LTR_J, LT_Q, 17'd0, 17'd0), 1'b0);

		// random: mostly well-formed references, some broken, some pure noise
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			calm = i >= 450 && i < 570;
			pick = $urandom_range(99);
			if (pick < 20) begin
				item.zone_number = 6'($urandom);
				item.band_letter = 5'($urandom);
				item.column_letter = 5'($urandom);
				item.row_letter = 5'($urandom);
				item.square_easting = 17'($urandom);
				item.square_northing = 17'($urandom);
			end else begin
				if ($urandom_range(3) == 0) begin
					// polar reference
					item.zone_number = '0;
					case ($urandom_range(3))
						0: item.band_letter = LT_A;
						1: item.band_letter = LT_B;
						2: item.band_letter = LTR_Y;
						default: item.band_letter = LTR_Z;
					endcase
					lo = (item.band_letter == LT_A || item.band_letter == LTR_Y) ? LTR_J : LT_A;
					hi = (item.band_letter == LT_B) ? LTR_R :
						(item.band_letter == LTR_Z) ? LTR_J : LTR_Z;
					rhi = (item.band_letter >= LTR_Y) ? LTR_P : LTR_Z;
					item.column_letter = pick_letter(lo, hi, POLAR_SKIP);
					item.row_letter = pick_letter(LT_A, rhi, '0);
					item.square_easting = 17'($urandom_range(131071));
					item.square_northing = 17'($urandom_range(131071));
				end else begin
					// utm reference with column inside the zone set
					item.zone_number = 6'($urandom_range(60, 1));
					item.band_letter = pick_letter(LTR_C, LTR_X, '0);
					case (item.zone_number % 3)
						1: begin lo = LT_A; hi = LT_H; end
						2: begin lo = LTR_J; hi = LTR_R; end
						default: begin lo = LTR_S; hi = LTR_Z; end
					endcase
					item.column_letter = pick_letter(lo, hi, '0);
					item.row_letter = pick_letter(LT_A, LTR_V, '0);
					item.square_easting = square_metres();
					item.square_northing = square_metres();
				end
				// break one field now and then
				if (pick < 32) begin
					case ($urandom_range(5))
						0: item.zone_number = 6'($urandom);
						1: item.band_letter = 5'($urandom);
						2: item.column_letter = 5'($urandom);
						3: item.row_letter = 5'($urandom);
						4: item.square_easting = 17'($urandom);
						default: item.square_northing = 17'($urandom);
					endcase
				end
			end
			send_reference(item, i == 300 || i == 700);
		end
		calm = 1'b0;
		req_valid <= 1'b0;

		while (ledger.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.awaited.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
